// ----- hdl/rrp_pkg.sv -----
// package: widths, type codes, class and error encodings, stage payload types
`timescale 1ns / 1ps

package rrp_pkg;

    localparam int WORD_W    = 64;
    localparam int TYPE_W    = 8;
    localparam int SECTION_W = 16;
    localparam int PCREL_W   = 32;

    typedef logic [WORD_W-1:0]    word_t;
    typedef logic [TYPE_W-1:0]    rtype_t;
    typedef logic [SECTION_W-1:0] section_t;
    typedef logic [PCREL_W-1:0]   pcrel_t;

    localparam section_t SHN_ABSOLUTE = 16'hfff1;

    localparam rtype_t TY_64           = 8'd2;
    localparam rtype_t TY_BRANCH       = 8'd16;
    localparam rtype_t TY_JAL          = 8'd17;
    localparam rtype_t TY_CALL         = 8'd18;
    localparam rtype_t TY_CALL_PLT     = 8'd19;
    localparam rtype_t TY_PCREL_HI20   = 8'd23;
    localparam rtype_t TY_PCREL_LO12_I = 8'd24;
    localparam rtype_t TY_ADD16        = 8'd34;
    localparam rtype_t TY_ADD32        = 8'd35;
    localparam rtype_t TY_SUB16        = 8'd38;
    localparam rtype_t TY_SUB32        = 8'd39;
    localparam rtype_t TY_ALIGN        = 8'd43;
    localparam rtype_t TY_RVC_BRANCH   = 8'd44;
    localparam rtype_t TY_RVC_JUMP     = 8'd45;
    localparam rtype_t TY_RELAX        = 8'd51;

    typedef logic [1:0] wwidth_t;
    localparam wwidth_t WIDTH_NONE = 2'd0;
    localparam wwidth_t WIDTH_16   = 2'd1;
    localparam wwidth_t WIDTH_32   = 2'd2;
    localparam wwidth_t WIDTH_64   = 2'd3;

    typedef enum logic [1:0] {
        ERR_OK      = 2'd0,
        ERR_SECTION = 2'd1,
        ERR_TYPE    = 2'd2
    } err_t;

    typedef enum logic [3:0] {
        CLS_NONE,
        CLS_ABS64,
        CLS_B,
        CLS_J,
        CLS_PAIR,
        CLS_CB,
        CLS_CJ,
        CLS_ADD16,
        CLS_SUB16,
        CLS_ADD32,
        CLS_SUB32
    } cls_t;

    typedef struct packed {
        cls_t  cls;
        err_t  err;
        word_t sb;
        word_t addend;
        word_t place;
        word_t old;
    } dec_t;

    typedef struct packed {
        cls_t  cls;
        err_t  err;
        word_t s;
        word_t place;
        word_t old;
    } sum_t;

    typedef struct packed {
        cls_t   cls;
        err_t   err;
        word_t  s;
        pcrel_t p;
        word_t  old;
    } rel_t;

endpackage

// ----- hdl/rrp_if.sv -----
// interfaces: relocation beat, result beat and section count write channel
`timescale 1ns / 1ps

interface rrp_in_if import rrp_pkg::*; ();
    logic            valid;
    logic            ready;
    rtype_t          reloc_type;
    word_t           symbol_value;
    section_t        symbol_section;
    word_t           section_base;
    logic signed [WORD_W-1:0] addend;
    word_t           place_address;
    word_t           old_word;

    modport source (output valid, reloc_type, symbol_value, symbol_section, section_base,
                    addend, place_address, old_word, input ready);
    modport sink   (input valid, reloc_type, symbol_value, symbol_section, section_base,
                    addend, place_address, old_word, output ready);
endinterface

interface rrp_out_if import rrp_pkg::*; ();
    logic    valid;
    logic    ready;
    word_t   new_word;
    wwidth_t write_width;
    logic [1:0] error_code;

    modport source (output valid, new_word, write_width, error_code, input ready);
    modport sink   (input valid, new_word, write_width, error_code, output ready);
endinterface

interface rrp_cfg_if import rrp_pkg::*; ();
    logic     valid;
    logic     ready;
    section_t section_count;

    modport source (output valid, section_count, input ready);
    modport sink   (input valid, section_count, output ready);
endinterface

// ----- hdl/rrp_decode.sv -----
// first stage: section check, type decode, symbol plus base
`timescale 1ns / 1ps

module rrp_decode import rrp_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  section_t  section_count,
    rrp_in_if.sink    reloc,
    output logic      dec_valid,
    input  logic      dec_ready,
    output dec_t      dec
);

    logic  valid_reg;
    dec_t  dec_reg;
    dec_t  dec_next;
    logic  advance;
    cls_t  cls;
    logic  known;
    logic  abs_sec;
    logic  bad_sec;

    assign advance     = !valid_reg || dec_ready;
    assign reloc.ready = advance;
    assign dec_valid   = valid_reg;
    assign dec         = dec_reg;

    always_comb
    begin
        known = 1'b1;
        case (reloc.reloc_type)
            TY_64:                                  cls = CLS_ABS64;
            TY_BRANCH:                              cls = CLS_B;
            TY_JAL:                                 cls = CLS_J;
            TY_CALL, TY_CALL_PLT, TY_PCREL_HI20:    cls = CLS_PAIR;
            TY_RVC_BRANCH:                          cls = CLS_CB;
            TY_RVC_JUMP:                            cls = CLS_CJ;
            TY_ADD16:                               cls = CLS_ADD16;
            TY_SUB16:                               cls = CLS_SUB16;
            TY_ADD32:                               cls = CLS_ADD32;
            TY_SUB32:                               cls = CLS_SUB32;
            TY_PCREL_LO12_I, TY_ALIGN, TY_RELAX:    cls = CLS_NONE;
            default:
            begin
                cls   = CLS_NONE;
                known = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        abs_sec         = (reloc.symbol_section == SHN_ABSOLUTE);
        bad_sec         = !abs_sec && (reloc.symbol_section >= section_count);
        dec_next.addend = word_t'($unsigned(reloc.addend));
        dec_next.place  = reloc.place_address;
        dec_next.old    = reloc.old_word;
        dec_next.sb     = abs_sec ? reloc.symbol_value
                                  : reloc.symbol_value + reloc.section_base;
        if (bad_sec)
        begin
            dec_next.err = ERR_SECTION;
            dec_next.cls = CLS_NONE;
        end
        else if (!known)
        begin
            dec_next.err = ERR_TYPE;
            dec_next.cls = CLS_NONE;
        end
        else
        begin
            dec_next.err = ERR_OK;
            dec_next.cls = cls;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= reloc.valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance && reloc.valid)
            dec_reg <= dec_next;
    end

    a_err_no_cls: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && dec_reg.err != ERR_OK |-> dec_reg.cls == CLS_NONE)
        else $error("error beat carries a patch class");

    a_sec_err: assert property (@(posedge clk) disable iff (!rst_n)
        reloc.valid && advance && reloc.symbol_section == SHN_ABSOLUTE
        |=> dec_reg.err != ERR_SECTION)
        else $error("absolute section flagged invalid");

endmodule

// ----- hdl/rrp_sum.sv -----
// two stages: target value s, then pc-relative offset p
`timescale 1ns / 1ps

module rrp_sum import rrp_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  dec_valid,
    output logic  dec_ready,
    input  dec_t  dec,
    output logic  rel_valid,
    input  logic  rel_ready,
    output rel_t  rel
);

    logic  sum_valid_reg;
    sum_t  sum_reg;
    sum_t  sum_next;
    logic  rel_valid_reg;
    rel_t  rel_reg;
    rel_t  rel_next;
    logic  sum_adv;
    logic  rel_adv;

    assign rel_adv   = !rel_valid_reg || rel_ready;
    assign sum_adv   = !sum_valid_reg || rel_adv;
    assign dec_ready = sum_adv;
    assign rel_valid = rel_valid_reg;
    assign rel       = rel_reg;

    always_comb
    begin
        sum_next.cls   = dec.cls;
        sum_next.err   = dec.err;
        sum_next.s     = dec.sb + dec.addend;
        sum_next.place = dec.place;
        sum_next.old   = dec.old;
    end

    always_comb
    begin
        rel_next.cls = sum_reg.cls;
        rel_next.err = sum_reg.err;
        rel_next.s   = sum_reg.s;
        rel_next.p   = sum_reg.s[PCREL_W-1:0] - sum_reg.place[PCREL_W-1:0];
        rel_next.old = sum_reg.old;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_valid_reg <= 1'b0;
            rel_valid_reg <= 1'b0;
        end
        else
        begin
            if (sum_adv)
                sum_valid_reg <= dec_valid;
            if (rel_adv)
                rel_valid_reg <= sum_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sum_adv && dec_valid)
            sum_reg <= sum_next;
        if (rel_adv && sum_valid_reg)
            rel_reg <= rel_next;
    end

endmodule

// ----- hdl/rrp_patch.sv -----
// last stage: immediate encoding, data update and result register
`timescale 1ns / 1ps

module rrp_patch import rrp_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    rel_valid,
    output logic    rel_ready,
    input  rel_t    rel,
    rrp_out_if.source result
);

    logic    valid_reg;
    word_t   word_reg;
    word_t   word_next;
    wwidth_t width_reg;
    wwidth_t width_next;
    err_t    err_reg;
    logic    advance;
    word_t   old;
    pcrel_t  p;
    logic [19:0] hi20;
    logic [15:0] w16;
    logic [31:0] w32;

    assign advance            = !valid_reg || result.ready;
    assign rel_ready          = advance;
    assign result.valid       = valid_reg;
    assign result.new_word    = word_reg;
    assign result.write_width = width_reg;
    assign result.error_code  = err_reg;

    always_comb
    begin
        old  = rel.old;
        p    = rel.p;
        w16  = old[15:0];
        w32  = old[31:0];
        hi20 = p[31:12] + {19'd0, p[11]};
        word_next  = old;
        width_next = WIDTH_NONE;
        case (rel.cls)
            CLS_ABS64:
            begin
                word_next  = rel.s;
                width_next = WIDTH_64;
            end
            CLS_B:
            begin
                word_next  = {old[63:32], p[12], p[10:5], w32[24:12], p[4:1], p[11], w32[6:0]};
                width_next = WIDTH_32;
            end
            CLS_J:
            begin
                word_next  = {old[63:32], p[20], p[10:1], p[11], p[19:12], w32[11:0]};
                width_next = WIDTH_32;
            end
            CLS_PAIR:
            begin
                word_next  = {p[11:0], old[51:32], hi20, old[11:0]};
                width_next = WIDTH_64;
            end
            CLS_CB:
            begin
                word_next  = {old[63:16], w16[15:13], p[8], p[4:3], w16[9:7], p[7:6],
                              p[2:1], p[5], w16[1:0]};
                width_next = WIDTH_16;
            end
            CLS_CJ:
            begin
                word_next  = {old[63:16], w16[15:13], p[11], p[4], p[9:8], p[10], p[6], p[7],
                              p[3:1], p[5], w16[1:0]};
                width_next = WIDTH_16;
            end
            CLS_ADD16:
            begin
                word_next  = {old[63:16], w16 + rel.s[15:0]};
                width_next = WIDTH_16;
            end
            CLS_SUB16:
            begin
                word_next  = {old[63:16], w16 - rel.s[15:0]};
                width_next = WIDTH_16;
            end
            CLS_ADD32:
            begin
                word_next  = {old[63:32], w32 + rel.s[31:0]};
                width_next = WIDTH_32;
            end
            CLS_SUB32:
            begin
                word_next  = {old[63:32], w32 - rel.s[31:0]};
                width_next = WIDTH_32;
            end
            default:
            begin
                word_next  = old;
                width_next = WIDTH_NONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= rel_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance && rel_valid)
        begin
            word_reg  <= word_next;
            width_reg <= width_next;
            err_reg   <= rel.err;
        end
    end

    a_err_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && err_reg != ERR_OK |-> width_reg == WIDTH_NONE)
        else $error("error result reports a write");

    a_err_keeps_word: assert property (@(posedge clk) disable iff (!rst_n)
        advance && rel_valid && rel.err != ERR_OK |=> word_reg == $past(rel.old))
        else $error("error result changed the word");

endmodule

// ----- hdl/riscv_relocation_patcher_top.sv -----
// top level: section count register and the four-stage relocation pipeline
// path: an input beat passes the decode, sum, offset and result registers in that order
// throughput: one relocation per cycle; a stalled result holds the stages behind it
// each stage register frees as soon as its beat moves on, so bubbles close up
// reset clears all stage valid bits and sets section_count to zero
`timescale 1ns / 1ps

module riscv_relocation_patcher_top import rrp_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    rrp_cfg_if.sink   cfg,
    rrp_in_if.sink    reloc,
    rrp_out_if.source result
);

    section_t count_reg;
    logic     dec_valid;
    logic     dec_ready;
    dec_t     dec;
    logic     rel_valid;
    logic     rel_ready;
    rel_t     rel;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (cfg.valid)
            count_reg <= cfg.section_count;
    end

    rrp_decode u_decode (
        .clk           (clk),
        .rst_n         (rst_n),
        .section_count (count_reg),
        .reloc         (reloc),
        .dec_valid     (dec_valid),
        .dec_ready     (dec_ready),
        .dec           (dec)
    );

    rrp_sum u_sum (
        .clk       (clk),
        .rst_n     (rst_n),
        .dec_valid (dec_valid),
        .dec_ready (dec_ready),
        .dec       (dec),
        .rel_valid (rel_valid),
        .rel_ready (rel_ready),
        .rel       (rel)
    );

    rrp_patch u_patch (
        .clk       (clk),
        .rst_n     (rst_n),
        .rel_valid (rel_valid),
        .rel_ready (rel_ready),
        .rel       (rel),
        .result    (result)
    );

    a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> result.error_code != 2'd3)
        else $error("result error code out of range");

    a_stall_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
        dec_valid && !dec_ready |-> !reloc.ready)
        else $error("input accepted while first stage is blocked");

endmodule
